FILE: sv/led_pwm_frame_packer_refresh_unit_macros.svh
// Assertion macros used by the frame packer top level.
`ifndef LED_PWM_FRAME_PACKER_REFRESH_UNIT_MACROS_SVH
`define LED_PWM_FRAME_PACKER_REFRESH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LPF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/lpf_pkg.sv
// Shared types and constants of the LED PWM frame packer.
`default_nettype none

package lpf_pkg;

	localparam int ACTION_W  = 3;
	localparam int CHANNEL_W = 5;
	localparam int VALUE_W   = 12;
	localparam int BYTE_W    = 8;
	localparam int DC_W      = 6;
	// byte index before range check; 3 * 31 fits in 7 bits
	localparam int IDX_W     = 7;

	// keep masks for read-modify-write of shared bytes
	localparam logic [BYTE_W-1:0] KEEP_NONE = 8'h00;
	localparam logic [BYTE_W-1:0] KEEP_LO2  = 8'h03;
	localparam logic [BYTE_W-1:0] KEEP_HI6  = 8'hFC;
	localparam logic [BYTE_W-1:0] KEEP_LO4  = 8'h0F;
	localparam logic [BYTE_W-1:0] KEEP_HI4  = 8'hF0;
	localparam logic [BYTE_W-1:0] KEEP_LO6  = 8'h3F;
	localparam logic [BYTE_W-1:0] KEEP_HI2  = 8'hC0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SET_GS     = 3'd0,
		ACT_SET_DC     = 3'd1,
		ACT_SET_ALL_GS = 3'd2,
		ACT_SET_ALL_DC = 3'd3,
		ACT_REQ_UPDATE = 3'd4,
		ACT_CYCLE_TICK = 3'd5,
		ACT_SEND_DC    = 3'd6
	} action_t;

	typedef struct packed {
		action_t              op;
		logic [CHANNEL_W-1:0] slot;
		logic [VALUE_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              blank;
		logic              latch;
		logic              extra;
		logic              prog;
		logic              dcsrc;
		logic              last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_FILL,
		ST_TICK_CTRL,
		ST_STREAM,
		ST_DC_LATCH
	} st_t;

endpackage

`default_nettype wire

FILE: sv/lpf_front.sv
// Front end: accepts input words, drops ignored ones and forms commands.
`default_nettype none

module lpf_front #(
	parameter int CHANNEL_COUNT = 16
) (
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [lpf_pkg::ACTION_W-1:0]   action,
	input  wire logic [lpf_pkg::CHANNEL_W-1:0]  channel,
	input  wire logic [lpf_pkg::VALUE_W-1:0]    value,
	input  wire lpf_pkg::q_stat_t               stat,
	output logic                                push,
	output lpf_pkg::cmd_t                       cmd
);

	localparam logic [lpf_pkg::CHANNEL_W:0] CC_L = (lpf_pkg::CHANNEL_W + 1)'(CHANNEL_COUNT);
	localparam logic [lpf_pkg::CHANNEL_W-1:0] TOP_SLOT = lpf_pkg::CHANNEL_W'(CHANNEL_COUNT - 1);

	logic in_range;
	logic keep_word;

	assign in_ready = !stat.full;
	assign in_range = ({1'b0, channel} < CC_L);

	// classify: drop out-of-range channel writes and the unused code
	always_comb begin
		keep_word = 1'b0;
		cmd.op    = lpf_pkg::ACT_REQ_UPDATE;
		cmd.slot  = TOP_SLOT - channel;
		cmd.value = value;
		case (lpf_pkg::action_t'(action))
			lpf_pkg::ACT_SET_GS: begin
				keep_word = in_range;
				cmd.op    = lpf_pkg::ACT_SET_GS;
			end
			lpf_pkg::ACT_SET_DC: begin
				keep_word = in_range;
				cmd.op    = lpf_pkg::ACT_SET_DC;
				cmd.value = {{(lpf_pkg::VALUE_W - lpf_pkg::DC_W){1'b0}},
					value[lpf_pkg::DC_W-1:0]};
			end
			lpf_pkg::ACT_SET_ALL_GS: begin
				keep_word = 1'b1;
				cmd.op    = lpf_pkg::ACT_SET_ALL_GS;
			end
			lpf_pkg::ACT_SET_ALL_DC: begin
				keep_word = 1'b1;
				cmd.op    = lpf_pkg::ACT_SET_ALL_DC;
				cmd.value = {{(lpf_pkg::VALUE_W - lpf_pkg::DC_W){1'b0}},
					value[lpf_pkg::DC_W-1:0]};
			end
			lpf_pkg::ACT_REQ_UPDATE: begin
				keep_word = 1'b1;
				cmd.op    = lpf_pkg::ACT_REQ_UPDATE;
			end
			lpf_pkg::ACT_CYCLE_TICK: begin
				keep_word = 1'b1;
				cmd.op    = lpf_pkg::ACT_CYCLE_TICK;
			end
			lpf_pkg::ACT_SEND_DC: begin
				keep_word = 1'b1;
				cmd.op    = lpf_pkg::ACT_SEND_DC;
			end
			default: begin
				keep_word = 1'b0;
			end
		endcase
	end

	assign push = in_valid && in_ready && keep_word;

endmodule

`default_nettype wire

FILE: sv/lpf_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module lpf_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lpf_pkg::cmd_t    wr_cmd,
	input  wire logic             pop,
	output lpf_pkg::cmd_t         rd_cmd,
	output lpf_pkg::q_stat_t      stat
);

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	lpf_pkg::cmd_t    ent_q [Q_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_cmd;
		end
	end

	assign rd_cmd     = ent_q[rp_q];
	assign stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

FILE: sv/lpf_back.sv
// Back end: frame stores, command sequencer and output register.
`default_nettype none

module lpf_back #(
	parameter int CHANNEL_COUNT = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpf_pkg::q_stat_t    stat,
	input  wire lpf_pkg::cmd_t       cmd,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output lpf_pkg::item_t           out_item
);

	localparam int GS_BYTES = (CHANNEL_COUNT * 3 + 1) / 2;
	localparam int DC_BYTES = (CHANNEL_COUNT * 3 + 3) / 4;
	localparam int AW       = $clog2(GS_BYTES);
	localparam int DC_AW    = $clog2(DC_BYTES);
	localparam int BW       = lpf_pkg::BYTE_W;
	localparam int IW       = lpf_pkg::IDX_W;
	localparam logic [AW-1:0] GS_LAST = AW'(GS_BYTES - 1);
	localparam logic [AW-1:0] DC_LAST = AW'(DC_BYTES - 1);
	localparam logic [IW-1:0] GS_LIM  = IW'(GS_BYTES);
	localparam logic [IW-1:0] DC_LIM  = IW'(DC_BYTES);

	// frame stores and their valid bits
	logic [BW-1:0]       gs_mem [GS_BYTES];
	logic [BW-1:0]       dc_mem [DC_BYTES];
	logic [GS_BYTES-1:0] gs_vld_q;
	logic [DC_BYTES-1:0] dc_vld_q;
	logic [BW-1:0]       gs_rd_q;
	logic [BW-1:0]       dc_rd_q;
	logic                gs_rv_q;
	logic                dc_rv_q;

	lpf_pkg::st_t   state_q;
	lpf_pkg::st_t   state_d;
	logic [AW-1:0]  cnt_q;
	logic [1:0]     mod3_q;
	logic [BW-1:0]  pat_q [3];
	logic           sel_dc_q;
	logic [AW-1:0]  op_addr_q [2];
	logic [BW-1:0]  op_keep_q [2];
	logic [BW-1:0]  op_bits_q [2];
	logic [1:0]     op_v_q;
	logic           op_k_q;
	logic           tick_latch_q;
	logic           tick_extra_q;
	logic           update_pending_q;
	logic           latch_pending_q;
	logic           program_mode_q;
	logic           dc_source_q;

	logic                out_valid_q;
	lpf_pkg::item_t      out_item_q;

	logic           out_free;
	logic           load;
	lpf_pkg::item_t item_d;
	logic [AW-1:0]  rd_addr;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [BW-1:0]  mem_wd;
	logic [BW-1:0]  cur_byte;
	logic           at_end;
	logic [AW-1:0]  end_idx;

	// decoded single-channel write
	logic [IW-1:0]  dec_addr [2];
	logic [BW-1:0]  dec_keep [2];
	logic [BW-1:0]  dec_bits [2];
	logic [1:0]     dec_v;
	logic [BW-1:0]  dec_pat [3];

	assign out_free  = !out_valid_q || out_ready;
	assign cur_byte  = sel_dc_q ? (dc_rv_q ? dc_rd_q : '0) : (gs_rv_q ? gs_rd_q : '0);
	assign end_idx   = sel_dc_q ? DC_LAST : GS_LAST;
	assign at_end    = (cnt_q == end_idx);

	// decode byte positions, masks and fill pattern from the queue head
	always_comb begin
		logic [IW-1:0] r;
		logic [IW-1:0] gs_i;
		logic [IW-1:0] dc_i;
		logic [IW-1:0] lim;
		logic          two;
		r    = {{(IW - lpf_pkg::CHANNEL_W){1'b0}}, cmd.slot};
		gs_i = r + (r >> 1);
		dc_i = (r + (r << 1)) >> 2;
		two  = 1'b1;
		lim  = GS_LIM;
		dec_addr[0] = gs_i;
		dec_addr[1] = gs_i + IW'(1);
		dec_keep[0] = lpf_pkg::KEEP_NONE;
		dec_keep[1] = lpf_pkg::KEEP_LO4;
		dec_bits[0] = cmd.value[11:4];
		dec_bits[1] = {cmd.value[3:0], 4'b0};
		dec_pat[0]  = cmd.value[11:4];
		dec_pat[1]  = {cmd.value[3:0], cmd.value[11:8]};
		dec_pat[2]  = cmd.value[7:0];
		if (cmd.op == lpf_pkg::ACT_SET_DC || cmd.op == lpf_pkg::ACT_SET_ALL_DC) begin
			lim         = DC_LIM;
			dec_addr[0] = dc_i;
			dec_addr[1] = dc_i + IW'(1);
			dec_pat[0]  = {cmd.value[5:0], cmd.value[5:4]};
			dec_pat[1]  = {cmd.value[3:0], cmd.value[5:2]};
			dec_pat[2]  = {cmd.value[1:0], cmd.value[5:0]};
			case (cmd.slot[1:0])
				2'd0: begin
					two         = 1'b0;
					dec_keep[0] = lpf_pkg::KEEP_LO2;
					dec_bits[0] = {cmd.value[5:0], 2'b0};
				end
				2'd1: begin
					dec_keep[0] = lpf_pkg::KEEP_HI6;
					dec_bits[0] = {6'b0, cmd.value[5:4]};
					dec_keep[1] = lpf_pkg::KEEP_LO4;
					dec_bits[1] = {cmd.value[3:0], 4'b0};
				end
				2'd2: begin
					dec_keep[0] = lpf_pkg::KEEP_HI4;
					dec_bits[0] = {4'b0, cmd.value[5:2]};
					dec_keep[1] = lpf_pkg::KEEP_LO6;
					dec_bits[1] = {cmd.value[1:0], 6'b0};
				end
				default: begin
					two         = 1'b0;
					dec_keep[0] = lpf_pkg::KEEP_HI2;
					dec_bits[0] = {2'b0, cmd.value[5:0]};
				end
			endcase
		end else if (cmd.op == lpf_pkg::ACT_SET_GS && cmd.slot[0]) begin
			dec_keep[0] = lpf_pkg::KEEP_HI4;
			dec_bits[0] = {4'b0, cmd.value[11:8]};
			dec_keep[1] = lpf_pkg::KEEP_NONE;
			dec_bits[1] = cmd.value[7:0];
		end
		dec_v[0] = (dec_addr[0] < lim);
		dec_v[1] = two && (dec_addr[1] < lim);
	end

	// sequencer: next state, memory port and output load
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_addr = '0;
		mem_we  = 1'b0;
		mem_wa  = cnt_q;
		mem_wd  = pat_q[mod3_q];
		load    = 1'b0;
		item_d  = '0;
		item_d.prog  = program_mode_q;
		item_d.dcsrc = dc_source_q;
		case (state_q)
			lpf_pkg::ST_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					case (cmd.op)
						lpf_pkg::ACT_SET_GS, lpf_pkg::ACT_SET_DC: begin
							if (dec_v != 2'b00) begin
								state_d = lpf_pkg::ST_RMW_RD;
							end
						end
						lpf_pkg::ACT_SET_ALL_GS, lpf_pkg::ACT_SET_ALL_DC: begin
							state_d = lpf_pkg::ST_FILL;
						end
						lpf_pkg::ACT_CYCLE_TICK: begin
							state_d = lpf_pkg::ST_TICK_CTRL;
						end
						lpf_pkg::ACT_SEND_DC: begin
							state_d = lpf_pkg::ST_STREAM;
						end
						default: begin
							state_d = lpf_pkg::ST_IDLE;
						end
					endcase
				end
			end
			lpf_pkg::ST_RMW_RD: begin
				rd_addr = op_addr_q[op_k_q];
				state_d = lpf_pkg::ST_RMW_WR;
			end
			lpf_pkg::ST_RMW_WR: begin
				mem_we  = 1'b1;
				mem_wa  = op_addr_q[op_k_q];
				mem_wd  = (cur_byte & op_keep_q[op_k_q]) | op_bits_q[op_k_q];
				state_d = (!op_k_q && op_v_q[1]) ? lpf_pkg::ST_RMW_RD : lpf_pkg::ST_IDLE;
			end
			lpf_pkg::ST_FILL: begin
				mem_we = 1'b1;
				if (at_end) begin
					state_d = lpf_pkg::ST_IDLE;
				end
			end
			lpf_pkg::ST_TICK_CTRL: begin
				if (out_free) begin
					load         = 1'b1;
					item_d.blank = 1'b1;
					item_d.latch = tick_latch_q;
					item_d.extra = tick_extra_q;
					item_d.last  = !update_pending_q;
					state_d = update_pending_q ? lpf_pkg::ST_STREAM : lpf_pkg::ST_IDLE;
				end
			end
			lpf_pkg::ST_STREAM: begin
				rd_addr = cnt_q;
				if (out_free) begin
					load        = 1'b1;
					item_d.kind = 1'b1;
					item_d.data = cur_byte;
					item_d.last = at_end && !sel_dc_q;
					if (at_end) begin
						rd_addr = '0;
						state_d = sel_dc_q ? lpf_pkg::ST_DC_LATCH : lpf_pkg::ST_IDLE;
					end else begin
						rd_addr = cnt_q + AW'(1);
					end
				end
			end
			lpf_pkg::ST_DC_LATCH: begin
				if (out_free) begin
					load         = 1'b1;
					item_d.latch = 1'b1;
					item_d.last  = 1'b1;
					state_d      = lpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpf_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control flags and store valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_pending_q <= 1'b1;
			latch_pending_q  <= 1'b0;
			program_mode_q   <= 1'b1;
			dc_source_q      <= 1'b0;
			gs_vld_q         <= '0;
			dc_vld_q         <= '0;
			gs_rv_q          <= 1'b0;
			dc_rv_q          <= 1'b0;
		end else begin
			gs_rv_q <= gs_vld_q[rd_addr];
			dc_rv_q <= dc_vld_q[rd_addr[DC_AW-1:0]];
			if (mem_we) begin
				if (sel_dc_q) begin
					dc_vld_q[mem_wa[DC_AW-1:0]] <= 1'b1;
				end else begin
					gs_vld_q[mem_wa] <= 1'b1;
				end
			end
			if (pop) begin
				case (cmd.op)
					lpf_pkg::ACT_REQ_UPDATE: begin
						update_pending_q <= 1'b1;
					end
					lpf_pkg::ACT_CYCLE_TICK: begin
						program_mode_q  <= 1'b0;
						latch_pending_q <= 1'b0;
					end
					lpf_pkg::ACT_SEND_DC: begin
						program_mode_q <= 1'b1;
						dc_source_q    <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (state_q == lpf_pkg::ST_TICK_CTRL && load && update_pending_q) begin
				update_pending_q <= 1'b0;
				latch_pending_q  <= 1'b1;
			end
		end
	end

	// hold command operands, counters and pattern
	always_ff @(posedge clk) begin
		if (pop) begin
			sel_dc_q     <= (cmd.op == lpf_pkg::ACT_SET_DC) ||
				(cmd.op == lpf_pkg::ACT_SET_ALL_DC) || (cmd.op == lpf_pkg::ACT_SEND_DC);
			cnt_q        <= '0;
			mod3_q       <= 2'd0;
			pat_q[0]     <= dec_pat[0];
			pat_q[1]     <= dec_pat[1];
			pat_q[2]     <= dec_pat[2];
			op_addr_q[0] <= dec_addr[0][AW-1:0];
			op_addr_q[1] <= dec_addr[1][AW-1:0];
			op_keep_q[0] <= dec_keep[0];
			op_keep_q[1] <= dec_keep[1];
			op_bits_q[0] <= dec_bits[0];
			op_bits_q[1] <= dec_bits[1];
			op_v_q       <= dec_v;
			op_k_q       <= !dec_v[0];
			tick_latch_q <= latch_pending_q;
			tick_extra_q <= program_mode_q;
		end else begin
			if (state_q == lpf_pkg::ST_RMW_WR) begin
				op_k_q <= 1'b1;
			end
			if (state_q == lpf_pkg::ST_FILL) begin
				cnt_q  <= cnt_q + AW'(1);
				mod3_q <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
			end
			if (state_q == lpf_pkg::ST_STREAM && load) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (state_q == lpf_pkg::ST_TICK_CTRL) begin
				cnt_q    <= '0;
				sel_dc_q <= 1'b0;
			end
		end
	end

	// frame store ports: one write, one registered read each
	always_ff @(posedge clk) begin
		gs_rd_q <= gs_mem[rd_addr];
		dc_rd_q <= dc_mem[rd_addr[DC_AW-1:0]];
		if (mem_we) begin
			if (sel_dc_q) begin
				dc_mem[mem_wa[DC_AW-1:0]] <= mem_wd;
			end else begin
				gs_mem[mem_wa] <= mem_wd;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= item_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

FILE: sv/led_pwm_frame_packer_refresh_unit.sv
// Top level of the LED PWM shift-frame packer and refresh sequencer.
//
// Input channel (in_valid/in_ready): one word per action with action, channel
// and value. Set words change the packed grayscale or dot-correction frame;
// request, tick and send-dc words drive the refresh sequence.
// Output channel (out_valid/out_ready): control items and serial data bytes,
// one word per cycle while the receiver keeps out_ready high; last marks the
// final word caused by one input word.
// Timing: a word enters a two-entry command queue, so the input side keeps
// accepting while the back end works. The back end pops a command; a set
// word then reads and then writes each touched byte (one or two, store read
// then write), and a set-all word writes every frame byte in turn.
// A cycle tick gives 1 + GS bytes words (control word, then the grayscale
// frame when an update is pending) and send-dc DC bytes + 1 words. Within a
// result sequence one word per cycle follows while out_ready stays high; the
// single store port paces the read-modify-write and fill work, the output
// register paces the streams.
// Reset: stores read as zero, an update is pending, dot-correction mode is on.
// A stalled receiver holds the output word; the back end waits and the queue
// then fills, dropping in_ready.
`default_nettype none
`include "led_pwm_frame_packer_refresh_unit_macros.svh"

module led_pwm_frame_packer_refresh_unit #(
	parameter int CHANNEL_COUNT = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [lpf_pkg::ACTION_W-1:0]   action,
	input  wire logic [lpf_pkg::CHANNEL_W-1:0]  channel,
	input  wire logic [lpf_pkg::VALUE_W-1:0]    value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                item_kind,
	output logic [lpf_pkg::BYTE_W-1:0]          data_byte,
	output logic                                blank_pulse,
	output logic                                latch_pulse,
	output logic                                extra_clock_pulse,
	output logic                                program_level,
	output logic                                dc_source_level,
	output logic                                last
);

	lpf_pkg::q_stat_t q_stat;
	lpf_pkg::cmd_t    wr_cmd;
	lpf_pkg::cmd_t    rd_cmd;
	lpf_pkg::item_t   item;
	logic             push;
	logic             pop;

	lpf_front #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.channel  (channel),
		.value    (value),
		.stat     (q_stat),
		.push     (push),
		.cmd      (wr_cmd)
	);

	lpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (q_stat)
	);

	lpf_back #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (q_stat),
		.cmd       (rd_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (item)
	);

	// unpack the output word
	assign item_kind         = item.kind;
	assign data_byte         = item.data;
	assign blank_pulse       = item.blank;
	assign latch_pulse       = item.latch;
	assign extra_clock_pulse = item.extra;
	assign program_level     = item.prog;
	assign dc_source_level   = item.dcsrc;
	assign last              = item.last;

	`LPF_ASSERT_IMPLY(a_full_stalls_input, q_stat.full, !in_ready, "input taken while queue full")
	`LPF_ASSERT_IMPLY(a_data_no_pulses, out_valid && item_kind, !blank_pulse && !latch_pulse && !extra_clock_pulse, "pulse on data byte")
	`LPF_ASSERT_IMPLY(a_data_levels, out_valid && item_kind, !program_level || dc_source_level, "data byte with wrong line levels")
	`LPF_ASSERT_NEXT(a_no_gap, out_valid && !last, out_valid, "gap inside a result sequence")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the LED PWM shift-frame packer and refresh sequencer.
module tb_top;
	import lpf_pkg::*;

	localparam int NCH      = 16;
	localparam int GS_BYTES = (NCH * 3 + 1) / 2;
	localparam int DC_BYTES = (NCH * 3 + 3) / 4;
	localparam int N_RANDOM = 280;
	localparam int END_WAIT = 64;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

	typedef struct packed {
		logic [ACTION_W-1:0]  act;
		logic [CHANNEL_W-1:0] ch;
		logic [VALUE_W-1:0]   val;
		logic                 drain;
		logic [2:0]           gap;
	} cmd_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action;
	logic [CHANNEL_W-1:0] channel;
	logic [VALUE_W-1:0]   value;
	logic                 out_valid;
	logic                 out_ready;
	logic                 item_kind;
	logic [BYTE_W-1:0]    data_byte;
	logic                 blank_pulse;
	logic                 latch_pulse;
	logic                 extra_clock_pulse;
	logic                 program_level;
	logic                 dc_source_level;
	logic                 last;

	// shadow copy of the block state
	logic [BYTE_W-1:0] gs_frame [GS_BYTES];
	logic [BYTE_W-1:0] dc_frame [DC_BYTES];
	logic              upd_pend;
	logic              lat_pend;
	logic              prog_mode;
	logic              dc_src;

	item_t     frame_words [$];
	cmd_word_t cmd_backlog [$];

	int errors;
	int words_sent;
	int words_taken;
	int results_taken;
	int results_seen;
	int items_made;
	int tx_idle;
	int rx_stall;
	int rx_left;
	bit rx_calm;
	bit tx_calm;

	led_pwm_frame_packer_refresh_unit #(
		.CHANNEL_COUNT(NCH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.channel(channel),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.data_byte(data_byte),
		.blank_pulse(blank_pulse),
		.latch_pulse(latch_pulse),
		.extra_clock_pulse(extra_clock_pulse),
		.program_level(program_level),
		.dc_source_level(dc_source_level),
		.last(last)
	);

	always #6 clk = ~clk;

	// queue one expected output word with the current line levels
	function automatic void push_word(logic kind, logic [BYTE_W-1:0] data, logic blank,
			logic latch, logic extra, logic fin);
		item_t w;
		w.kind  = kind;
		w.data  = data;
		w.blank = blank;
		w.latch = latch;
		w.extra = extra;
		w.prog  = prog_mode;
		w.dcsrc = dc_src;
		w.last  = fin;
		frame_words.push_back(w);
	endfunction

	function automatic void put_gs(int idx, logic [BYTE_W-1:0] keep, logic [BYTE_W-1:0] bits);
		if (idx < GS_BYTES)
			gs_frame[idx] = (gs_frame[idx] & keep) | bits;
	endfunction

	function automatic void put_dc(int idx, logic [BYTE_W-1:0] keep, logic [BYTE_W-1:0] bits);
		if (idx < DC_BYTES)
			dc_frame[idx] = (dc_frame[idx] & keep) | bits;
	endfunction

	// apply one action to the shadow frames and queue the words it produces
	function automatic void refresh_step(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
			logic [VALUE_W-1:0] v);
		int          r;
		int          i;
		logic [5:0]  d;
		logic        lat;
		logic        ext;
		logic [7:0]  pat [3];
		r = NCH - 1 - int'(ch);
		d = v[5:0];
		case (act)
			ACT_SET_GS: begin
				if (int'(ch) < NCH) begin
					i = r * 3 / 2;
					if (r % 2 == 0) begin
						put_gs(i, KEEP_NONE, v[11:4]);
						put_gs(i + 1, KEEP_LO4, {v[3:0], 4'h0});
					end else begin
						put_gs(i, KEEP_HI4, {4'h0, v[11:8]});
						put_gs(i + 1, KEEP_NONE, v[7:0]);
					end
				end
			end
			ACT_SET_DC: begin
				if (int'(ch) < NCH) begin
					i = r * 3 / 4;
					case (r % 4)
						0: put_dc(i, KEEP_LO2, {d, 2'b00});
						1: begin
							put_dc(i, KEEP_HI6, {6'h00, d[5:4]});
							put_dc(i + 1, KEEP_LO4, {d[3:0], 4'h0});
						end
						2: begin
							put_dc(i, KEEP_HI4, {4'h0, d[5:2]});
							put_dc(i + 1, KEEP_LO6, {d[1:0], 6'h00});
						end
						default: put_dc(i, KEEP_HI2, {2'b00, d});
					endcase
				end
			end
			ACT_SET_ALL_GS: begin
				pat[0] = v[11:4];
				pat[1] = {v[3:0], v[11:8]};
				pat[2] = v[7:0];
				for (i = 0; i < GS_BYTES; i++)
					gs_frame[i] = pat[i % 3];
			end
			ACT_SET_ALL_DC: begin
				pat[0] = {d, d[5:4]};
				pat[1] = {d[3:0], d[5:2]};
				pat[2] = {d[1:0], d};
				for (i = 0; i < DC_BYTES; i++)
					dc_frame[i] = pat[i % 3];
			end
			ACT_REQ_UPDATE: upd_pend = 1'b1;
			ACT_CYCLE_TICK: begin
				lat = 1'b0;
				ext = 1'b0;
				if (prog_mode) begin
					prog_mode = 1'b0;
					ext = 1'b1;
				end
				if (lat_pend) begin
					lat = 1'b1;
					lat_pend = 1'b0;
				end
				push_word(1'b0, 8'h00, 1'b1, lat, ext, !upd_pend);
				if (upd_pend) begin
					for (i = 0; i < GS_BYTES; i++)
						push_word(1'b1, gs_frame[i], 1'b0, 1'b0, 1'b0, i == GS_BYTES - 1);
					lat_pend = 1'b1;
					upd_pend = 1'b0;
				end
			end
			ACT_SEND_DC: begin
				dc_src = 1'b1;
				prog_mode = 1'b1;
				for (i = 0; i < DC_BYTES; i++)
					push_word(1'b1, dc_frame[i], 1'b0, 1'b0, 1'b0, 1'b0);
				push_word(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// append one command word to the backlog with its leading gap
	task automatic add_item(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
			logic [VALUE_W-1:0] val, logic drain);
		cmd_word_t c;
		c.act   = act;
		c.ch    = ch;
		c.val   = val;
		c.drain = drain;
		c.gap   = tx_calm ? 3'd0 : 3'($urandom_range(0, 5));
		cmd_backlog.push_back(c);
		items_made++;
	endtask

	// random channel, mostly in range
	function automatic logic [CHANNEL_W-1:0] pick_channel();
		if ($urandom_range(0, 7) == 0)
			return CHANNEL_W'($urandom_range(0, 31));
		return CHANNEL_W'($urandom_range(0, NCH - 1));
	endfunction

	// check results and predict accepted words at the rising edge
	always @(posedge clk) begin : monitor
		item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_taken <= results_taken + 1;
				if (frame_words.size() == 0) begin
					$error("unexpected output word: kind %0d byte %0h", item_kind, data_byte);
					errors++;
				end else begin
					want = frame_words.pop_front();
					check_field("item_kind", want.kind, item_kind);
					check_field("data_byte", want.data, data_byte);
					check_field("blank_pulse", want.blank, blank_pulse);
					check_field("latch_pulse", want.latch, latch_pulse);
					check_field("extra_clock_pulse", want.extra, extra_clock_pulse);
					check_field("program_level", want.prog, program_level);
					check_field("dc_source_level", want.dcsrc, dc_source_level);
					check_field("last", want.last, last);
				end
			end
			if (in_valid && in_ready) begin
				refresh_step(action, channel, value);
				words_taken <= words_taken + 1;
			end
		end
	end

	// present command words at the falling edge
	always @(negedge clk) begin : driver
		cmd_word_t c;
		if (arst_n) begin
			if (!in_valid || words_taken == words_sent) begin
				if (cmd_backlog.size() != 0 && tx_idle >= int'(cmd_backlog[0].gap) &&
				    !(cmd_backlog[0].drain && frame_words.size() != 0)) begin
					c = cmd_backlog.pop_front();
					action     <= c.act;
					channel    <= c.ch;
					value      <= c.val;
					in_valid   <= 1'b1;
					words_sent <= words_sent + 1;
					tx_idle    <= 0;
				end else begin
					in_valid <= 1'b0;
					tx_idle  <= tx_idle + 1;
				end
			end
		end
	end

	// stall the output side at random, with calm runs in between
	always @(negedge clk) begin : receiver
		int s;
		if (arst_n) begin
			s = rx_stall;
			if (results_taken != results_seen) begin
				results_seen <= results_taken;
				if (rx_left == 0) begin
					rx_calm = ($urandom_range(0, 2) == 0);
					rx_left = 40;
				end
				rx_left--;
				s = rx_calm ? 0 : $urandom_range(0, 5);
			end
			if (s > 0) begin
				out_ready <= 1'b0;
				rx_stall  <= s - 1;
			end else begin
				out_ready <= 1'b1;
				rx_stall  <= 0;
			end
		end
	end

	initial begin : timeout
		#6000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int n;
		int k;
		int seq;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		channel = '0;
		value = '0;
		out_ready = 1'b0;
		errors = 0;
		words_sent = 0;
		words_taken = 0;
		results_taken = 0;
		results_seen = 0;
		items_made = 0;
		tx_idle = 0;
		rx_stall = 0;
		rx_left = 0;
		rx_calm = 1'b0;
		tx_calm = 1'b0;
		foreach (gs_frame[i])
			gs_frame[i] = '0;
		foreach (dc_frame[i])
			dc_frame[i] = '0;
		upd_pend = 1'b1;
		lat_pend = 1'b0;
		prog_mode = 1'b1;
		dc_src = 1'b0;

		// directed: field extremes, ignored channels, masking, every action
		add_item(ACT_SET_GS, 5'd0, 12'hFFF, 1'b0);
		add_item(ACT_SET_GS, 5'd15, 12'hABC, 1'b0);
		add_item(ACT_SET_GS, 5'd1, 12'h5A5, 1'b0);
		add_item(ACT_SET_GS, 5'd16, 12'h123, 1'b0);
		add_item(ACT_SET_GS, 5'd31, 12'hFFF, 1'b0);
		add_item(ACT_SET_DC, 5'd0, 12'h03F, 1'b0);
		add_item(ACT_SET_DC, 5'd1, 12'hFFF, 1'b0);
		add_item(ACT_SET_DC, 5'd2, 12'h02A, 1'b0);
		add_item(ACT_SET_DC, 5'd3, 12'h015, 1'b0);
		add_item(ACT_SET_DC, 5'd31, 12'h03F, 1'b0);
		add_item(ACT_UNUSED, 5'd31, 12'hFFF, 1'b0);
		add_item(ACT_CYCLE_TICK, 5'd0, 12'h000, 1'b1);
		add_item(ACT_CYCLE_TICK, 5'd0, 12'h000, 1'b1);
		add_item(ACT_CYCLE_TICK, 5'd31, 12'hFFF, 1'b0);
		add_item(ACT_SEND_DC, 5'd0, 12'h000, 1'b0);
		add_item(ACT_CYCLE_TICK, 5'd0, 12'h000, 1'b0);
		add_item(ACT_SET_ALL_GS, 5'd0, 12'hFFF, 1'b0);
		add_item(ACT_REQ_UPDATE, 5'd0, 12'h000, 1'b0);
		add_item(ACT_CYCLE_TICK, 5'd0, 12'h000, 1'b0);
		add_item(ACT_SET_ALL_DC, 5'd0, 12'hFC0, 1'b0);
		add_item(ACT_SEND_DC, 5'd0, 12'h000, 1'b0);
		add_item(ACT_SET_ALL_DC, 5'd0, 12'h03F, 1'b0);
		add_item(ACT_SET_ALL_GS, 5'd0, 12'h000, 1'b0);
		add_item(ACT_REQ_UPDATE, 5'd0, 12'h000, 1'b0);
		add_item(ACT_SEND_DC, 5'd0, 12'h000, 1'b0);
		add_item(ACT_CYCLE_TICK, 5'd0, 12'h000, 1'b0);

		// random: mostly write-update-tick sequences, some dot-correction sends and noise
		n = items_made + N_RANDOM;
		seq = 0;
		while (items_made < n) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 9);
			if (k < 7) begin
				if ($urandom_range(0, 5) == 0)
					add_item(ACT_SET_ALL_GS, CHANNEL_W'($urandom),
						VALUE_W'($urandom), seq == 0 || $urandom_range(0, 11) == 0);
				repeat ($urandom_range(1, 6))
					add_item($urandom_range(0, 1) ? ACT_SET_GS : ACT_SET_DC, pick_channel(),
						VALUE_W'($urandom), 1'b0);
				add_item(ACT_REQ_UPDATE, CHANNEL_W'($urandom), VALUE_W'($urandom), 1'b0);
				add_item(ACT_CYCLE_TICK, CHANNEL_W'($urandom), VALUE_W'($urandom), 1'b0);
				if ($urandom_range(0, 2) == 0)
					add_item(ACT_CYCLE_TICK, CHANNEL_W'($urandom), VALUE_W'($urandom), 1'b0);
			end else if (k == 7) begin
				if ($urandom_range(0, 1) == 0)
					add_item(ACT_SET_ALL_DC, CHANNEL_W'($urandom), VALUE_W'($urandom), 1'b0);
				add_item(ACT_SEND_DC, CHANNEL_W'($urandom), VALUE_W'($urandom),
					$urandom_range(0, 11) == 0);
				add_item(ACT_CYCLE_TICK, CHANNEL_W'($urandom), VALUE_W'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 4))
					add_item(ACTION_W'($urandom_range(0, 7)), CHANNEL_W'($urandom),
						VALUE_W'($urandom), 1'b0);
			end
			seq++;
		end

		// hold reset, then release it on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain everything, then let the block settle
		while (cmd_backlog.size() != 0 || words_taken != words_sent || in_valid ||
		       frame_words.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (errors == 0 && frame_words.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/lpf_pkg.sv
sv/lpf_front.sv
sv/lpf_queue.sv
sv/lpf_back.sv
sv/led_pwm_frame_packer_refresh_unit.sv
tb/tb_top.sv
